### rtl/core/lcg_byte_pattern_checker_unit_defines.svh
// Assertion macros used by the checker file of the pattern checker unit.
`ifndef LCG_BYTE_PATTERN_CHECKER_UNIT_DEFINES_SVH
`define LCG_BYTE_PATTERN_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LBPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lbpc_pkg.sv
// Package of the LCG byte pattern checker: word types, constants, LCG step.
`default_nettype none
package lbpc_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int REPORT_W        = 32;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [30:0] LCG_MUL = 31'(64'd1103515245);
	localparam logic [30:0] LCG_ADD = 31'd12345;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0]          expected_byte;
		logic                byte_mismatch;
		logic                run_done;
		logic [REPORT_W-1:0] report_offset;
	} out_word_t;

	// classified item handed from front to back (offset travels beside it)
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] expected_byte;
		logic       last_byte;
	} cls_t;

	// bits 30..16 of v*mul+add need only the low 31 product bits
	function automatic logic [15:0] lcg_next(input logic [15:0] v);
		logic [30:0] p;
		p = 31'(v) * LCG_MUL + LCG_ADD;
		return {1'b0, p[30:16]};
	endfunction

endpackage
`default_nettype wire

### rtl/core/lbpc_front.sv
// Front end: seed register, pattern generator and byte offset counter.
`default_nettype none
module lbpc_front #(
	parameter int OFFSET_BITS = lbpc_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	input  wire logic [15:0]            cfg_data,
	input  wire logic                   accept,
	input  wire lbpc_pkg::in_word_t     in_word,
	output lbpc_pkg::cls_t              cls,
	output logic [OFFSET_BITS-1:0]      cls_pos
);

	logic [15:0]            seed_q;
	logic [15:0]            pattern_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   run_active_q;
	logic [15:0]            cur_val;
	logic                   odd;

	assign cur_val = run_active_q ? pattern_q : seed_q;
	assign odd     = pos_q[0];

	always_comb begin
		cls.data_byte     = in_word.data_byte;
		cls.last_byte     = in_word.last_byte;
		cls.expected_byte = odd ? cur_val[15:8] : cur_val[7:0];
		cls_pos           = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid) begin
			seed_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= '0;
			pos_q        <= '0;
			run_active_q <= 1'b0;
		end else if (accept) begin
			pattern_q    <= odd ? lbpc_pkg::lcg_next(cur_val) : cur_val;
			run_active_q <= !in_word.last_byte;
			pos_q        <= in_word.last_byte ? '0 : pos_q + OFFSET_BITS'(1);
		end
	end

endmodule
`default_nettype wire

### rtl/core/lbpc_fifo.sv
// Short queue between front and back.
`default_nettype none
module lbpc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lbpc_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			// count holds when both or neither side moves
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/lbpc_back.sv
// Back end: compare, first-mismatch tracking, run report and output register.
`default_nettype none
module lbpc_back #(
	parameter int OFFSET_BITS = lbpc_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_empty,
	input  wire lbpc_pkg::cls_t         q_cls,
	input  wire logic [OFFSET_BITS-1:0] q_pos,
	output logic                        q_pop,
	input  wire logic                   pop,
	output logic                        empty,
	output lbpc_pkg::out_word_t         out_word
);

	localparam int ExtW = (OFFSET_BITS > lbpc_pkg::REPORT_W) ? OFFSET_BITS
	                                                         : lbpc_pkg::REPORT_W;

	logic                   out_valid_q;
	lbpc_pkg::out_word_t    out_q;
	logic                   err_seen_q;
	logic [OFFSET_BITS-1:0] first_err_q;
	logic                   mismatch;
	logic [OFFSET_BITS-1:0] first_sel;
	logic [OFFSET_BITS-1:0] report;
	logic [ExtW-1:0]        report_ext;

	assign q_pop    = !q_empty && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign out_word = out_q;

	always_comb begin
		mismatch  = (q_cls.data_byte != q_cls.expected_byte);
		first_sel = err_seen_q ? first_err_q : q_pos;
		if (!q_cls.last_byte) begin
			report = '0;
		end else if (err_seen_q || mismatch) begin
			report = first_sel;
		end else begin
			report = q_pos + OFFSET_BITS'(1);
		end
		report_ext = ExtW'(report);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q.expected_byte <= q_cls.expected_byte;
			out_q.byte_mismatch <= mismatch;
			out_q.run_done      <= q_cls.last_byte;
			out_q.report_offset <= report_ext[lbpc_pkg::REPORT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			err_seen_q  <= 1'b0;
			first_err_q <= '0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (q_cls.last_byte) begin
					err_seen_q  <= 1'b0;
					first_err_q <= '0;
				end else if (mismatch && !err_seen_q) begin
					err_seen_q  <= 1'b1;
					first_err_q <= q_pos;
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/lcg_byte_pattern_checker_unit.sv
// Top level of the LCG byte pattern checker unit.
//
// channel   direction  handshake              word
// input     in         push / full            in_word  (data_byte, last_byte)
// result    out        pop / empty            out_word (expected_byte, byte_mismatch,
//                                                        run_done, report_offset)
// config    in         cfg_valid / cfg_ready  cfg_data (pattern_seed)
//
// One word per cycle in and out, sustained while pop is high. The front is
// combinational and writes the queue at the accepting edge; the output register takes
// the queue head when free. full rises only when the four-entry queue and the output
// register are all occupied, i.e. after the result side has stalled.
// arst_n clears seed, position, error tracking, queue and output valid.
// cfg_ready is always high; a new seed applies from the next run.
`default_nettype none
module lcg_byte_pattern_checker_unit #(
	parameter int OFFSET_BITS = lbpc_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input words
	input  wire logic                push,
	output logic                     full,
	input  wire lbpc_pkg::in_word_t  in_word,
	// result words
	output logic                     empty,
	input  wire logic                pop,
	output lbpc_pkg::out_word_t      out_word,
	// seed register
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [15:0]         cfg_data
);

	localparam int QW = $bits(lbpc_pkg::cls_t) + OFFSET_BITS;

	logic                   accept;
	lbpc_pkg::cls_t         f_cls;
	logic [OFFSET_BITS-1:0] f_pos;
	logic [QW-1:0]          q_rd;
	logic                   q_empty;
	logic                   q_pop;
	lbpc_pkg::cls_t         b_cls;
	logic [OFFSET_BITS-1:0] b_pos;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// front: generate the expected byte and tag it with its offset
	lbpc_front #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.in_word   (in_word),
		.cls       (f_cls),
		.cls_pos   (f_pos)
	);

	// decoupling queue; its full flag is the input back-pressure
	lbpc_fifo #(
		.WIDTH (QW),
		.DEPTH (lbpc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data ({f_cls, f_pos}),
		.rd_en   (q_pop),
		.rd_data (q_rd),
		.full    (full),
		.empty   (q_empty)
	);

	assign b_cls = q_rd[QW-1:OFFSET_BITS];
	assign b_pos = q_rd[OFFSET_BITS-1:0];

	// back: compare, track first mismatch, build the run report
	lbpc_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_cls    (b_cls),
		.q_pos    (b_pos),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.out_word (out_word)
	);

endmodule
`default_nettype wire

### rtl/core/lbpc_checker.sv
// Port-level assertions for the pattern checker unit, bound to the top level.
`default_nettype none
`include "lcg_byte_pattern_checker_unit_defines.svh"
module lbpc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                full,
	input wire logic                empty,
	input wire logic                pop,
	input wire lbpc_pkg::out_word_t out_word
);

	// a waiting result holds until it is taken
	`LBPC_ASSERT_NXT(a_result_held, (!empty && !pop), (!empty && $stable(out_word)), "result changed while stalled")

	// report is zero except on the last word of a run
	`LBPC_ASSERT_IMP(a_report_zero, (!empty && !out_word.run_done), (out_word.report_offset == 32'd0), "report outside run end")

	// the queue only fills up behind an occupied output register
	`LBPC_ASSERT_IMP(a_full_not_empty, full, !empty, "full with empty output")

endmodule

bind lcg_byte_pattern_checker_unit lbpc_checker u_lbpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_word (out_word)
);
`default_nettype wire
